/* hw/rtl/dbu_pkg.sv */
`timescale 1ns / 1ps
// Package for the detection box unmapper: payload types, widths, register
// indexes, mode codes and the output saturation function. No dependencies.
package dbu_pkg;

    localparam int FRAC_BITS = 15;
    localparam int FIELD_W   = 16;
    localparam int MODE_W    = 2;
    localparam int COEF_W    = 23;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = COEF_W;
    // Signed coordinate: a field minus an offset.
    localparam int COORD_W   = FIELD_W + 1;
    // Signed product of a coordinate and a zero-extended coefficient.
    localparam int PROD_W    = COORD_W + COEF_W + 1;
    localparam int QUOT_W    = PROD_W - FRAC_BITS;
    localparam int SUM_W     = QUOT_W + 1;
    localparam int CTR_W     = FIELD_W + 2;
    localparam int ONE_FX    = 1 << FRAC_BITS;

    localparam logic [FIELD_W-1:0]      ONE_FIELD = FIELD_W'(ONE_FX);
    localparam logic signed [SUM_W-1:0] ONE_S     = SUM_W'(ONE_FX);

    localparam logic [MODE_W-1:0] MODE_STRETCH   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_CROP      = 2'd1;
    localparam logic [MODE_W-1:0] MODE_LETTERBOX = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_MODE        = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SCALE_X     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SCALE_Y     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BASE_X      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_BASE_Y      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_INV_SCALE_X = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_INV_SCALE_Y = 3'd6;

    typedef struct packed {
        logic [FIELD_W-1:0] box_x;
        logic [FIELD_W-1:0] box_y;
        logic [FIELD_W-1:0] box_w;
        logic [FIELD_W-1:0] box_h;
    } t_box_in;

    typedef struct packed {
        logic [FIELD_W-1:0] out_x;
        logic [FIELD_W-1:0] out_y;
        logic [FIELD_W-1:0] out_w;
        logic [FIELD_W-1:0] out_h;
        logic               box_valid;
    } t_box_out;

    // Clamp a signed intermediate into [0, 1.0].
    function automatic logic [FIELD_W-1:0] sat_field(input logic signed [SUM_W-1:0] v);
        logic [FIELD_W-1:0] r;
        if (v[SUM_W-1]) begin
            r = '0;
        end else if (v > ONE_S) begin
            r = ONE_FIELD;
        end else begin
            r = v[FIELD_W-1:0];
        end
        return r;
    endfunction

endpackage

/* hw/rtl/dbu_if.sv */
`timescale 1ns / 1ps
// Valid/ready channel interfaces for box requests and box results.
// Depends on dbu_pkg for the payload types.
interface dbu_box_if
    import dbu_pkg::*;
();
    logic    valid;
    logic    ready;
    t_box_in payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface dbu_res_if
    import dbu_pkg::*;
();
    logic     valid;
    logic     ready;
    t_box_out payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

/* hw/rtl/detection_box_unmapper.sv */
`timescale 1ns / 1ps
// Detection box unmapper: maps a Q1.15 box from model space to source image space.
// Each accepted request passes the three register stages (multiply, offset, clamp) to
// o_res; one request per cycle is taken unless o_res stalls with every stage full.
// Reset (synchronous, active low) empties the pipeline and loads the register reset
// values: stretch mode, scale 1.0, offset 0, inverse scale 1.0.
// Depends on dbu_pkg and dbu_if.
module detection_box_unmapper
    import dbu_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_DAT_W-1:0] i_cfg_data,
    dbu_box_if.sink              i_box,
    dbu_res_if.source            o_res
);

    // Configuration registers.
    logic [MODE_W-1:0]  r_mode;
    logic [FIELD_W-1:0] r_scale_x, r_scale_y, r_base_x, r_base_y;
    logic [COEF_W-1:0]  r_inv_scale_x, r_inv_scale_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode        <= MODE_STRETCH;
            r_scale_x     <= ONE_FIELD;
            r_scale_y     <= ONE_FIELD;
            r_base_x      <= '0;
            r_base_y      <= '0;
            r_inv_scale_x <= COEF_W'(ONE_FX);
            r_inv_scale_y <= COEF_W'(ONE_FX);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_MODE:        r_mode        <= i_cfg_data[MODE_W-1:0];
                REG_SCALE_X:     r_scale_x     <= i_cfg_data[FIELD_W-1:0];
                REG_SCALE_Y:     r_scale_y     <= i_cfg_data[FIELD_W-1:0];
                REG_BASE_X:      r_base_x      <= i_cfg_data[FIELD_W-1:0];
                REG_BASE_Y:      r_base_y      <= i_cfg_data[FIELD_W-1:0];
                REG_INV_SCALE_X: r_inv_scale_x <= i_cfg_data;
                REG_INV_SCALE_Y: r_inv_scale_y <= i_cfg_data;
                default: ;
            endcase
        end
    end

    logic is_lb, is_crop;
    assign is_lb   = (r_mode == MODE_LETTERBOX);
    assign is_crop = (r_mode == MODE_CROP);

    // Stage enables: a stage moves when it is empty or its successor moves.
    logic r1_valid, r2_valid, r3_valid;
    logic en1, en2, en3;
    assign en3 = !r3_valid || o_res.ready;
    assign en2 = !r2_valid || en3;
    assign en1 = !r1_valid || en2;
    assign i_box.ready = en1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
            r3_valid <= 1'b0;
        end else begin
            if (en1) r1_valid <= i_box.valid;
            if (en2) r2_valid <= r1_valid;
            if (en3) r3_valid <= r2_valid;
        end
    end

    // Stage 1: one multiplier per field and the letterbox center test.
    logic signed [COORD_W-1:0]  n1_ax, n1_ay, n1_aw, n1_ah;
    logic signed [COEF_W:0]     n1_bx, n1_by;
    logic signed [PROD_W-1:0]   n1_px, n1_py, n1_pw, n1_ph;
    logic [CTR_W-1:0]           n1_cx2, n1_cy2, n1_lox, n1_loy, n1_hix, n1_hiy;
    logic                       n1_reject;
    logic signed [PROD_W-1:0]   r1_px, r1_py, r1_pw, r1_ph;
    logic                       r1_reject;
    t_box_in                    r1_in;

    always_comb begin
        if (is_lb) begin
            n1_ax = $signed({1'b0, i_box.payload.box_x}) - $signed({1'b0, r_base_x});
            n1_ay = $signed({1'b0, i_box.payload.box_y}) - $signed({1'b0, r_base_y});
            n1_bx = $signed({1'b0, r_inv_scale_x});
            n1_by = $signed({1'b0, r_inv_scale_y});
        end else begin
            n1_ax = $signed({1'b0, i_box.payload.box_x});
            n1_ay = $signed({1'b0, i_box.payload.box_y});
            n1_bx = $signed({1'b0, (COEF_W)'(r_scale_x)});
            n1_by = $signed({1'b0, (COEF_W)'(r_scale_y)});
        end
        n1_aw = $signed({1'b0, i_box.payload.box_w});
        n1_ah = $signed({1'b0, i_box.payload.box_h});
        n1_px = PROD_W'(n1_ax) * PROD_W'(n1_bx);
        n1_py = PROD_W'(n1_ay) * PROD_W'(n1_by);
        n1_pw = PROD_W'(n1_aw) * PROD_W'(n1_bx);
        n1_ph = PROD_W'(n1_ah) * PROD_W'(n1_by);

        // The center is compared at twice its value so that it stays exact.
        n1_cx2 = {1'b0, i_box.payload.box_x, 1'b0} + CTR_W'(i_box.payload.box_w);
        n1_cy2 = {1'b0, i_box.payload.box_y, 1'b0} + CTR_W'(i_box.payload.box_h);
        n1_lox = {1'b0, r_base_x, 1'b0};
        n1_loy = {1'b0, r_base_y, 1'b0};
        n1_hix = {(FIELD_W + 1)'(r_base_x) + (FIELD_W + 1)'(r_scale_x), 1'b0};
        n1_hiy = {(FIELD_W + 1)'(r_base_y) + (FIELD_W + 1)'(r_scale_y), 1'b0};
        n1_reject = is_lb && (n1_cx2 < n1_lox || n1_cx2 > n1_hix ||
                              n1_cy2 < n1_loy || n1_cy2 > n1_hiy);
    end

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r1_px     <= n1_px;
            r1_py     <= n1_py;
            r1_pw     <= n1_pw;
            r1_ph     <= n1_ph;
            r1_reject <= n1_reject;
            r1_in     <= i_box.payload;
        end
    end

    // Stage 2: drop the fraction bits (floor), add the crop offset, and fold a
    // negative letterbox edge into the size; other modes pass the input box through.
    logic signed [QUOT_W-1:0] q_x, q_y, q_w, q_h;
    logic signed [SUM_W-1:0]  n2_rx, n2_ry, n2_rw, n2_rh;
    logic signed [SUM_W-1:0]  r2_rx, r2_ry, r2_rw, r2_rh;
    logic                     r2_reject;
    t_box_in                  r2_in;

    assign q_x = r1_px[PROD_W-1:FRAC_BITS];
    assign q_y = r1_py[PROD_W-1:FRAC_BITS];
    assign q_w = r1_pw[PROD_W-1:FRAC_BITS];
    assign q_h = r1_ph[PROD_W-1:FRAC_BITS];

    always_comb begin
        if (is_crop) begin
            n2_rx = SUM_W'(q_x) + $signed(SUM_W'(r_base_x));
            n2_ry = SUM_W'(q_y) + $signed(SUM_W'(r_base_y));
            n2_rw = SUM_W'(q_w);
            n2_rh = SUM_W'(q_h);
        end else if (is_lb) begin
            n2_rx = SUM_W'(q_x);
            n2_ry = SUM_W'(q_y);
            n2_rw = SUM_W'(q_w);
            n2_rh = SUM_W'(q_h);
            if (q_x[QUOT_W-1]) begin
                n2_rw = SUM_W'(q_w) + SUM_W'(q_x);
                n2_rx = '0;
            end
            if (q_y[QUOT_W-1]) begin
                n2_rh = SUM_W'(q_h) + SUM_W'(q_y);
                n2_ry = '0;
            end
        end else begin
            n2_rx = $signed(SUM_W'(r1_in.box_x));
            n2_ry = $signed(SUM_W'(r1_in.box_y));
            n2_rw = $signed(SUM_W'(r1_in.box_w));
            n2_rh = $signed(SUM_W'(r1_in.box_h));
        end
    end

    always_ff @(posedge i_clk) begin
        if (en2) begin
            r2_rx     <= n2_rx;
            r2_ry     <= n2_ry;
            r2_rw     <= n2_rw;
            r2_rh     <= n2_rh;
            r2_reject <= r1_reject;
            r2_in     <= r1_in;
        end
    end

    // Stage 3: trim the overhang past 1.0, reject empty boxes, saturate.
    logic signed [SUM_W-1:0] n3_rw, n3_rh;
    logic                    n3_keep;
    t_box_out                n3_out;
    t_box_out                r3_out;

    always_comb begin
        n3_rw = r2_rw;
        n3_rh = r2_rh;
        if (is_lb && (r2_rx + r2_rw > ONE_S)) begin
            n3_rw = ONE_S - r2_rx;
        end
        if (is_lb && (r2_ry + r2_rh > ONE_S)) begin
            n3_rh = ONE_S - r2_ry;
        end
        n3_keep = !(is_lb && (r2_reject ||
                              n3_rw[SUM_W-1] || n3_rw == SUM_W'(0) ||
                              n3_rh[SUM_W-1] || n3_rh == SUM_W'(0)));
        if (n3_keep) begin
            n3_out.out_x = sat_field(r2_rx);
            n3_out.out_y = sat_field(r2_ry);
            n3_out.out_w = sat_field(n3_rw);
            n3_out.out_h = sat_field(n3_rh);
        end else begin
            n3_out.out_x = r2_in.box_x;
            n3_out.out_y = r2_in.box_y;
            n3_out.out_w = r2_in.box_w;
            n3_out.out_h = r2_in.box_h;
        end
        n3_out.box_valid = n3_keep;
    end

    always_ff @(posedge i_clk) begin
        if (en3) begin
            r3_out <= n3_out;
        end
    end

    assign o_res.valid   = r3_valid;
    assign o_res.payload = r3_out;

    // A kept box never leaves the unit square.
    a_kept_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.payload.box_valid) |->
        (o_res.payload.out_x <= ONE_FIELD && o_res.payload.out_y <= ONE_FIELD &&
         o_res.payload.out_w <= ONE_FIELD && o_res.payload.out_h <= ONE_FIELD))
        else $error("kept box outside [0, 1.0]");

    // With every stage full and the output stalled, no new request may enter.
    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r1_valid && r2_valid && r3_valid && !o_res.ready) |-> !i_box.ready)
        else $error("request taken into a full stalled pipeline");

    // A result waiting at the output is not dropped while the sink stalls.
    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r3_valid && !o_res.ready) |=> (r3_valid && $stable(r3_out)))
        else $error("stalled result lost or changed");

    // Reset empties the pipeline.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> (!r1_valid && !r2_valid && !r3_valid))
        else $error("pipeline not empty after reset");

endmodule

/* tb/sv/tb_detection_box_unmapper.sv */
`timescale 1ns / 1ps
// Testbench for detection_box_unmapper: a directed table, then random register phases and box
// requests, each checked against a typed result or a behavioral mapper under random stalls.
// Depends on dbu_pkg, dbu_if and the unmapper RTL.
module tb_detection_box_unmapper;
    import dbu_pkg::*;

    localparam logic [MODE_W-1:0]    MODE_UNUSED  = 2'd3;
    localparam logic [CFG_IDX_W-1:0] REG_NONE     = 3'd7;
    localparam int                   DRAIN_CYCLES = 8;
    localparam int                   HOLD_CYCLES  = 80;
    localparam int                   IDLE_LIMIT   = 2000;
    localparam int                   RAND_PHASES  = 13;

    typedef struct packed {
        logic [MODE_W-1:0]  mode;
        logic [FIELD_W-1:0] scale_x;
        logic [FIELD_W-1:0] scale_y;
        logic [FIELD_W-1:0] base_x;
        logic [FIELD_W-1:0] base_y;
        logic [COEF_W-1:0]  inv_x;
        logic [COEF_W-1:0]  inv_y;
    } t_map_cfg;

    typedef struct {
        int       cfg_sel;
        t_box_in  box;
        bit       typed;
        t_box_out res;
    } t_dir_row;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_idx;
    logic [CFG_DAT_W-1:0] cfg_data;

    dbu_box_if box_if ();
    dbu_res_if res_if ();

    detection_box_unmapper dut (
        .i_clk     (clk),
        .i_rst_n   (rst_n),
        .i_cfg_we  (cfg_we),
        .i_cfg_idx (cfg_idx),
        .i_cfg_data(cfg_data),
        .i_box     (box_if),
        .o_res     (res_if)
    );

    t_map_cfg cur_cfg;
    t_map_cfg dir_cfgs [6];
    t_dir_row dir_rows [$];
    t_box_out pending_boxes [$];
    int       n_errors    = 0;
    int       idle_cycles = 0;
    int       burst_left  = 0;
    bit       hold_req    = 1'b0;

    always begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Exact product shifted down with floor rounding; >>> on a signed value floors.
    function automatic longint fx_mul(longint a, longint b);
        return (a * b) >>> FRAC_BITS;
    endfunction

    function automatic logic [FIELD_W-1:0] clamp_unit(longint v);
        logic [FIELD_W-1:0] r;
        if (v < 0) begin
            r = '0;
        end else if (v > ONE_FX) begin
            r = ONE_FIELD;
        end else begin
            r = v[FIELD_W-1:0];
        end
        return r;
    endfunction

    function automatic t_box_out unmap_box(t_box_in b, t_map_cfg c);
        longint   x, y, w, h, sx, sy, ox, oy, rx, ry, rw, rh;
        bit       kept;
        t_box_out r;
        x    = b.box_x;
        y    = b.box_y;
        w    = b.box_w;
        h    = b.box_h;
        sx   = c.scale_x;
        sy   = c.scale_y;
        ox   = c.base_x;
        oy   = c.base_y;
        rx   = x;
        ry   = y;
        rw   = w;
        rh   = h;
        kept = 1'b1;
        case (c.mode)
            MODE_CROP: begin
                rx = ox + fx_mul(x, sx);
                ry = oy + fx_mul(y, sy);
                rw = fx_mul(w, sx);
                rh = fx_mul(h, sy);
            end
            MODE_LETTERBOX: begin
                // Doubled center against the doubled window, so no rounding enters the test.
                if (2 * x + w < 2 * ox || 2 * x + w > 2 * (ox + sx) ||
                    2 * y + h < 2 * oy || 2 * y + h > 2 * (oy + sy)) begin
                    kept = 1'b0;
                end else begin
                    rx = fx_mul(x - ox, c.inv_x);
                    ry = fx_mul(y - oy, c.inv_y);
                    rw = fx_mul(w, c.inv_x);
                    rh = fx_mul(h, c.inv_y);
                    if (rx < 0) begin
                        rw = rw + rx;
                        rx = 0;
                    end
                    if (ry < 0) begin
                        rh = rh + ry;
                        ry = 0;
                    end
                    if (rx + rw > ONE_FX) begin
                        rw = ONE_FX - rx;
                    end
                    if (ry + rh > ONE_FX) begin
                        rh = ONE_FX - ry;
                    end
                    if (rw <= 0 || rh <= 0) begin
                        kept = 1'b0;
                    end
                end
            end
            default: ;
        endcase
        if (kept) begin
            r = '{clamp_unit(rx), clamp_unit(ry), clamp_unit(rw), clamp_unit(rh), 1'b1};
        end else begin
            r = '{b.box_x, b.box_y, b.box_w, b.box_h, 1'b0};
        end
        return r;
    endfunction

    function automatic logic [FIELD_W-1:0] extreme_field();
        logic [FIELD_W-1:0] r;
        case ($urandom_range(0, 4))
            0:       r = '0;
            1:       r = FIELD_W'(1);
            2:       r = ONE_FIELD - FIELD_W'(1);
            3:       r = ONE_FIELD;
            default: r = '1;
        endcase
        return r;
    endfunction

    // Left or top edge of a box whose center falls somewhere in [base, base + extent].
    function automatic logic [FIELD_W-1:0] centered_edge(int base, int extent, int span);
        int e;
        e = base + int'($urandom_range(0, extent)) - span / 2;
        if (e < 0) begin
            e = 0;
        end
        return FIELD_W'(e);
    endfunction

    function automatic t_box_in rand_box(t_map_cfg c);
        t_box_in b;
        int      pick, w, h;
        pick = $urandom_range(0, 9);
        if (pick == 0) begin
            b = {$urandom, $urandom};
        end else if (pick == 1) begin
            b.box_x = extreme_field();
            b.box_y = extreme_field();
            b.box_w = extreme_field();
            b.box_h = extreme_field();
        end else if (c.mode == MODE_LETTERBOX) begin
            w = $urandom_range(1, ONE_FX / 2);
            h = $urandom_range(1, ONE_FX / 2);
            b.box_w = FIELD_W'(w);
            b.box_h = FIELD_W'(h);
            b.box_x = centered_edge(int'(c.base_x), int'(c.scale_x), w);
            b.box_y = centered_edge(int'(c.base_y), int'(c.scale_y), h);
        end else begin
            w = $urandom_range(0, ONE_FX);
            h = $urandom_range(0, ONE_FX);
            b.box_w = FIELD_W'(w);
            b.box_h = FIELD_W'(h);
            b.box_x = FIELD_W'($urandom_range(0, ONE_FX - w));
            b.box_y = FIELD_W'($urandom_range(0, ONE_FX - h));
        end
        return b;
    endfunction

    function automatic t_map_cfg rand_cfg();
        t_map_cfg c;
        int       pick, s;
        c.scale_x = FIELD_W'($urandom_range(0, ONE_FX));
        c.scale_y = FIELD_W'($urandom_range(0, ONE_FX));
        c.base_x  = FIELD_W'($urandom_range(0, ONE_FX));
        c.base_y  = FIELD_W'($urandom_range(0, ONE_FX));
        c.inv_x   = COEF_W'($urandom);
        c.inv_y   = COEF_W'($urandom);
        pick = $urandom_range(0, 9);
        if (pick == 0) begin
            c.mode = MODE_STRETCH;
        end else if (pick == 1) begin
            c.mode = MODE_UNUSED;
        end else if (pick <= 4) begin
            c.mode   = MODE_CROP;
            c.base_x = FIELD_W'($urandom_range(0, ONE_FX - int'(c.scale_x)));
            c.base_y = FIELD_W'($urandom_range(0, ONE_FX - int'(c.scale_y)));
        end else begin
            c.mode = MODE_LETTERBOX;
            // Mostly a consistent letterbox or pillarbox; otherwise the random values stand.
            if ($urandom_range(0, 7) != 0) begin
                s = $urandom_range(ONE_FX / 8, ONE_FX);
                if ($urandom_range(0, 1) == 1) begin
                    c.scale_x = ONE_FIELD;
                    c.base_x  = '0;
                    c.inv_x   = COEF_W'(ONE_FX);
                    c.scale_y = FIELD_W'(s);
                    c.base_y  = FIELD_W'((ONE_FX - s) / 2);
                    c.inv_y   = COEF_W'((1 << 30) / s);
                end else begin
                    c.scale_y = ONE_FIELD;
                    c.base_y  = '0;
                    c.inv_y   = COEF_W'(ONE_FX);
                    c.scale_x = FIELD_W'(s);
                    c.base_x  = FIELD_W'((ONE_FX - s) / 2);
                    c.inv_x   = COEF_W'((1 << 30) / s);
                end
            end
        end
        return c;
    endfunction

    task automatic add_row(int sel, t_box_in box, bit typed, t_box_out res);
        t_dir_row row;
        row.cfg_sel = sel;
        row.box     = box;
        row.typed   = typed;
        row.res     = res;
        dir_rows.push_back(row);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] data);
        @(negedge clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
    endtask

    // Bits above a register's width may carry junk, which the block must drop.
    task automatic program_regs(t_map_cfg c);
        logic [CFG_DAT_W-1:0] junk;
        junk = ($urandom_range(0, 1) == 1) ? CFG_DAT_W'($urandom) : '0;
        write_reg(REG_MODE,        {junk[CFG_DAT_W-1:MODE_W], c.mode});
        write_reg(REG_SCALE_X,     {junk[CFG_DAT_W-1:FIELD_W], c.scale_x});
        write_reg(REG_SCALE_Y,     {junk[CFG_DAT_W-1:FIELD_W], c.scale_y});
        write_reg(REG_BASE_X,      {junk[CFG_DAT_W-1:FIELD_W], c.base_x});
        write_reg(REG_BASE_Y,      {junk[CFG_DAT_W-1:FIELD_W], c.base_y});
        write_reg(REG_INV_SCALE_X, c.inv_x);
        write_reg(REG_INV_SCALE_Y, c.inv_y);
        write_reg(REG_NONE,        junk);
        @(negedge clk);
        cfg_we  <= 1'b0;
        cur_cfg = c;
    endtask

    task automatic settle_block();
        @(negedge clk);
        box_if.valid <= 1'b0;
        while (pending_boxes.size() != 0) begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic send_box(t_box_in b, t_box_out res);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            repeat (gap) begin
                @(negedge clk);
                box_if.valid <= 1'b0;
            end
            burst_left = $urandom_range(1, 24);
        end
        @(negedge clk);
        box_if.valid   <= 1'b1;
        box_if.payload <= b;
        do @(posedge clk); while (box_if.ready !== 1'b1);
        pending_boxes.push_back(res);
        burst_left--;
    endtask

    task automatic check_field(string name, logic [FIELD_W-1:0] want, logic [FIELD_W-1:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            n_errors++;
        end
    endtask

    always @(posedge clk) begin : res_check
        t_box_out want;
        if (res_if.valid === 1'b1 && res_if.ready === 1'b1) begin
            if (pending_boxes.size() == 0) begin
                $error("result arrived with no request outstanding");
                n_errors++;
            end else begin
                want = pending_boxes.pop_front();
                check_field("out_x", want.out_x, res_if.payload.out_x);
                check_field("out_y", want.out_y, res_if.payload.out_y);
                check_field("out_w", want.out_w, res_if.payload.out_w);
                check_field("out_h", want.out_h, res_if.payload.out_h);
                check_field("box_valid", FIELD_W'(want.box_valid),
                            FIELD_W'(res_if.payload.box_valid));
            end
        end
    end

    always @(posedge clk) begin
        if ((box_if.valid === 1'b1 && box_if.ready === 1'b1) ||
            (res_if.valid === 1'b1 && res_if.ready === 1'b1)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        wait (idle_cycles >= IDLE_LIMIT);
        $display("simulation failed");
        $finish;
    end

    // Result side: segments of steady, patterned or random ready, and a long hold on request.
    initial begin
        int         style, seg, hold_left;
        logic [7:0] mask;
        hold_left    = 0;
        res_if.ready = 1'b0;
        wait (rst_n === 1'b1);
        forever begin
            style = $urandom_range(0, 2);
            mask  = 8'($urandom) | 8'h01;
            seg   = $urandom_range(16, 96);
            repeat (seg) begin
                @(negedge clk);
                if (hold_left > 0) begin
                    res_if.ready <= 1'b0;
                    hold_left--;
                end else if (hold_req) begin
                    res_if.ready <= 1'b0;
                    hold_left = HOLD_CYCLES;
                    hold_req  = 1'b0;
                end else if (style == 0) begin
                    res_if.ready <= 1'b1;
                end else if (style == 1) begin
                    res_if.ready <= mask[0];
                    mask = {mask[0], mask[7:1]};
                end else begin
                    res_if.ready <= ($urandom_range(0, 9) < 7);
                end
            end
        end
    end

    initial begin
        t_map_cfg c;
        t_box_in  b;
        t_box_out res;
        int       cur_sel, n_items;
        rst_n          = 1'b0;
        cfg_we         = 1'b0;
        cfg_idx        = '0;
        cfg_data       = '0;
        box_if.valid   = 1'b0;
        box_if.payload = '0;
        cur_cfg = '{MODE_STRETCH, ONE_FIELD, ONE_FIELD, '0, '0, COEF_W'(ONE_FX), COEF_W'(ONE_FX)};

        dir_cfgs[0] = cur_cfg;
        dir_cfgs[1] = '{MODE_UNUSED, 16'd1000, 16'd2000, 16'd300, 16'd400, 23'd5000, 23'd6000};
        dir_cfgs[2] = '{MODE_CROP, 16'd16384, 16'd24576, 16'd8192, 16'd4096,
                        COEF_W'(ONE_FX), COEF_W'(ONE_FX)};
        dir_cfgs[3] = '{MODE_CROP, ONE_FIELD, ONE_FIELD, ONE_FIELD, ONE_FIELD,
                        COEF_W'(ONE_FX), COEF_W'(ONE_FX)};
        // Odd inverse scale so that a negative product has a fraction to floor.
        dir_cfgs[4] = '{MODE_LETTERBOX, ONE_FIELD, 16'd16384, 16'd0, 16'd8192,
                        COEF_W'(ONE_FX), 23'd65537};
        dir_cfgs[5] = '{MODE_LETTERBOX, 16'd0, 16'd0, 16'd16384, 16'd16384, '1, '1};

        // Reset values: stretch pass-through, with saturation of out-of-range fields.
        add_row(0, {16'd0, 16'd0, 16'd0, 16'd0}, 1'b1, {16'd0, 16'd0, 16'd0, 16'd0, 1'b1});
        add_row(0, {ONE_FIELD, ONE_FIELD, ONE_FIELD, ONE_FIELD}, 1'b1,
                {ONE_FIELD, ONE_FIELD, ONE_FIELD, ONE_FIELD, 1'b1});
        add_row(0, {16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF}, 1'b1,
                {ONE_FIELD, ONE_FIELD, ONE_FIELD, ONE_FIELD, 1'b1});
        add_row(0, {16'd12345, 16'd32767, 16'd1, 16'd20000}, 1'b0, '0);
        // The unused mode code behaves as stretch.
        add_row(1, {16'd1234, 16'd5678, 16'd9012, 16'd3456}, 1'b1,
                {16'd1234, 16'd5678, 16'd9012, 16'd3456, 1'b1});
        add_row(1, {16'd40000, 16'd0, ONE_FIELD, 16'd100}, 1'b1,
                {ONE_FIELD, 16'd0, ONE_FIELD, 16'd100, 1'b1});
        add_row(2, {16'd0, 16'd0, ONE_FIELD, ONE_FIELD}, 1'b0, '0);
        add_row(2, {ONE_FIELD, ONE_FIELD, ONE_FIELD, ONE_FIELD}, 1'b0, '0);
        add_row(2, {16'd12345, 16'd23456, 16'd3333, 16'd4444}, 1'b0, '0);
        // Full-scale crop overflows the edges and saturates them.
        add_row(3, {ONE_FIELD, ONE_FIELD, ONE_FIELD, ONE_FIELD}, 1'b1,
                {ONE_FIELD, ONE_FIELD, ONE_FIELD, ONE_FIELD, 1'b1});
        add_row(3, {16'd0, 16'd0, 16'd0, 16'd0}, 1'b1,
                {ONE_FIELD, ONE_FIELD, 16'd0, 16'd0, 1'b1});
        // Centers above, below and on the edges of the content window.
        add_row(4, {16'd1000, 16'd0, 16'd2000, 16'd100}, 1'b1,
                {16'd1000, 16'd0, 16'd2000, 16'd100, 1'b0});
        add_row(4, {16'd1000, 16'd30000, 16'd2000, 16'd2000}, 1'b1,
                {16'd1000, 16'd30000, 16'd2000, 16'd2000, 1'b0});
        add_row(4, {16'd1000, 16'd8000, 16'd2000, 16'd384}, 1'b0, '0);
        add_row(4, {16'd1000, 16'd24000, 16'd2000, 16'd1152}, 1'b0, '0);
        add_row(4, {16'd1000, 16'd24000, 16'd2000, 16'd1154}, 1'b1,
                {16'd1000, 16'd24000, 16'd2000, 16'd1154, 1'b0});
        add_row(4, {16'd0, 16'd8192, ONE_FIELD, 16'd16384}, 1'b0, '0);
        add_row(4, {16'd31000, 16'd10000, 16'd2000, 16'd2000}, 1'b0, '0);
        add_row(4, {16'd32000, 16'd10000, 16'd2000, 16'd2000}, 1'b0, '0);
        // Zero-sized content window with a huge inverse.
        add_row(5, {16'd16384, 16'd16384, 16'd0, 16'd0}, 1'b1,
                {16'd16384, 16'd16384, 16'd0, 16'd0, 1'b0});
        add_row(5, {16'd16000, 16'd16000, 16'd768, 16'd768}, 1'b0, '0);
        add_row(5, {ONE_FIELD, ONE_FIELD, ONE_FIELD, ONE_FIELD}, 1'b1,
                {ONE_FIELD, ONE_FIELD, ONE_FIELD, ONE_FIELD, 1'b0});

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        cur_sel = 0;
        foreach (dir_rows[i]) begin
            if (dir_rows[i].cfg_sel != cur_sel) begin
                settle_block();
                program_regs(dir_cfgs[dir_rows[i].cfg_sel]);
                cur_sel = dir_rows[i].cfg_sel;
            end
            res = dir_rows[i].typed ? dir_rows[i].res : unmap_box(dir_rows[i].box, cur_cfg);
            send_box(dir_rows[i].box, res);
        end

        for (int p = 0; p < RAND_PHASES; p++) begin
            case (p)
                0:       c = '{MODE_CROP, '0, '0, '0, '0, '0, '0};
                1:       c = '{MODE_LETTERBOX, ONE_FIELD, ONE_FIELD, ONE_FIELD, ONE_FIELD, '1, '1};
                2:       c = '{MODE_CROP, '1, '1, '1, '1, '1, '1};
                default: c = rand_cfg();
            endcase
            settle_block();
            program_regs(c);
            if (p == 3 || p == 9) begin
                hold_req = 1'b1;
            end
            n_items = $urandom_range(25, 45);
            repeat (n_items) begin
                b = rand_box(cur_cfg);
                send_box(b, unmap_box(b, cur_cfg));
            end
        end

        settle_block();
        if (n_errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
